// File: rtl/rph_pkg.sv
`timescale 1ns / 1ps

package rph_pkg;

	// field widths of the item channels
	localparam int CmdWidth   = 2;
	localparam int CoordWidth = 12;
	localparam int PixWidth   = 8;
	localparam int ResWidth   = 32;

	// configuration port
	localparam int CfgIdxWidth  = 3;
	localparam int CfgDataWidth = 12;

	typedef enum logic [CmdWidth-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [CfgIdxWidth-1:0] {
		REG_USE_ROI    = 3'd0,
		REG_ROI_LEFT   = 3'd1,
		REG_ROI_TOP    = 3'd2,
		REG_ROI_RIGHT  = 3'd3,
		REG_ROI_BOTTOM = 3'd4
	} reg_idx_t;

	localparam logic [CoordWidth-1:0] RoiRightReset  = '1;
	localparam logic [CoordWidth-1:0] RoiBottomReset = '1;

endpackage

// File: rtl/rph_pix_if.sv
`timescale 1ns / 1ps

// input item channel: command and pixel fields
interface rph_pix_if import rph_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CmdWidth-1:0]   command;
	logic [CoordWidth-1:0] pixel_x;
	logic [CoordWidth-1:0] pixel_y;
	logic [PixWidth-1:0]   pixel_value;
	logic [PixWidth-1:0]   bin_select;

	modport source (output valid, command, pixel_x, pixel_y, pixel_value, bin_select,
		input ready);
	modport sink (input valid, command, pixel_x, pixel_y, pixel_value, bin_select,
		output ready);
endinterface

// File: rtl/rph_res_if.sv
`timescale 1ns / 1ps

// result item channel: bin count
interface rph_res_if import rph_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ResWidth-1:0] bin_count;

	modport source (output valid, bin_count, input ready);
	modport sink (input valid, bin_count, output ready);
endinterface

// File: rtl/rph_cfg_if.sv
`timescale 1ns / 1ps

// register write channel
interface rph_cfg_if import rph_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CfgIdxWidth-1:0]  index;
	logic [CfgDataWidth-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/roi_pixel_histogram_unit.sv
`timescale 1ns / 1ps

// Histogram of 8-bit pixel indices with an optional inclusive region of interest.
// Each item is a clear, an add or a read (other codes do nothing); only a read returns a
// result item. The unit takes one item per clock: the bin counts live in a synchronous
// memory read when the item is taken and written back in the next cycle, and an add that
// follows an add of the same bin gets the fresh count forwarded into its read register. A
// read's result passes through stage 1 and then the result register; the item-per-clock rate
// is lost only when a read meets a full result register that is not being taken. Clear is a
// flash clear of the per-bin valid flops, with no clearing pass after reset.
module roi_pixel_histogram_unit import rph_pkg::*; #(
	parameter int NUM_BINS    = 256,
	parameter int COUNT_WIDTH = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	rph_pix_if.sink   pix,
	rph_res_if.source res,
	rph_cfg_if.sink   cfg
);

	localparam int BinAw = $clog2(NUM_BINS);
	localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

	// region registers
	logic                  use_roi_q;
	logic [CoordWidth-1:0] roi_left_q, roi_top_q, roi_right_q, roi_bottom_q;

	// bin store and valid marks
	logic [COUNT_WIDTH-1:0] bin_mem [NUM_BINS];
	logic [NUM_BINS-1:0]    bin_valid_q;

	// stage 1: memory read data is available
	logic                   valid_s1;
	logic [CmdWidth-1:0]    cmd_s1;
	logic [BinAw-1:0]       addr_s1;
	logic                   hit_s1;
	logic [COUNT_WIDTH-1:0] rd_s1;

	// result register
	logic                out_valid_q;
	logic [ResWidth-1:0] out_count_q;

	logic                   accept, in_region, in_hit, adv_s1, rd_adv, wr_en, cur_valid;
	logic [BinAw-1:0]       rd_addr;
	logic [COUNT_WIDTH-1:0] wr_data, rd_count;
	logic [63:0]            rd_wide;

	// config writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_roi_q    <= 1'b0;
			roi_left_q   <= '0;
			roi_top_q    <= '0;
			roi_right_q  <= RoiRightReset;
			roi_bottom_q <= RoiBottomReset;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_USE_ROI:    use_roi_q    <= cfg.data[0];
				REG_ROI_LEFT:   roi_left_q   <= cfg.data;
				REG_ROI_TOP:    roi_top_q    <= cfg.data;
				REG_ROI_RIGHT:  roi_right_q  <= cfg.data;
				REG_ROI_BOTTOM: roi_bottom_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input decode: region test, bin range and memory address
	always_comb begin
		in_region = !use_roi_q ||
			(pix.pixel_x >= roi_left_q && pix.pixel_x <= roi_right_q &&
			 pix.pixel_y >= roi_top_q && pix.pixel_y <= roi_bottom_q);
		if (pix.command == CMD_READ) begin
			rd_addr = BinAw'(pix.bin_select);
			in_hit  = 32'(pix.bin_select) < 32'(NUM_BINS);
		end else begin
			rd_addr = BinAw'(pix.pixel_value);
			in_hit  = (32'(pix.pixel_value) < 32'(NUM_BINS)) && in_region;
		end
	end

	// stage 1 modify: saturating increment, or first count of a cleared bin
	always_comb begin
		cur_valid = hit_s1 && bin_valid_q[addr_s1];
		wr_en     = valid_s1 && cmd_s1 == CMD_ADD && hit_s1;
		if (!cur_valid)
			wr_data = COUNT_WIDTH'(1);
		else if (rd_s1 == CountMax)
			wr_data = rd_s1;
		else
			wr_data = rd_s1 + COUNT_WIDTH'(1);
		rd_count = cur_valid ? rd_s1 : '0;
		rd_wide  = 64'(rd_count);
		adv_s1   = !(valid_s1 && cmd_s1 == CMD_READ && out_valid_q && !res.ready);
		rd_adv   = valid_s1 && cmd_s1 == CMD_READ && adv_s1;
	end

	assign pix.ready = adv_s1;
	assign accept    = pix.valid && pix.ready;

	// bin memory: read on accept with forwarding of the write in the same cycle
	always_ff @(posedge clk) begin
		if (accept)
			rd_s1 <= (wr_en && rd_addr == addr_s1) ? wr_data : bin_mem[rd_addr];
		if (wr_en)
			bin_mem[addr_s1] <= wr_data;
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= pix.command;
			addr_s1 <= rd_addr;
			hit_s1  <= in_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv_s1)
			valid_s1 <= accept;
	end

	// valid marks: flash clear, set on first count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bin_valid_q <= '0;
		else if (valid_s1 && cmd_s1 == CMD_CLEAR)
			bin_valid_q <= '0;
		else if (wr_en)
			bin_valid_q[addr_s1] <= 1'b1;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (rd_adv)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rd_adv)
			out_count_q <= rd_wide[ResWidth-1:0];
	end

	assign res.valid     = out_valid_q;
	assign res.bin_count = out_count_q;

	// checks
	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		rd_adv |=> out_valid_q)
		else $error("read left stage 1 without a result");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cmd_s1 == CMD_CLEAR) |=> (bin_valid_q == '0))
		else $error("valid marks not cleared");

	a_write_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_data != '0))
		else $error("add wrote a zero count");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> (valid_s1 && cmd_s1 == CMD_READ && out_valid_q && !res.ready))
		else $error("input stalled without a blocked read");

	a_write_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> bin_valid_q[$past(addr_s1)])
		else $error("written bin not marked valid");

endmodule

// File: bench/hist_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register channels of the histogram unit, keeps its own
// copy of the bins and region, and checks each result item against the oldest read.
module hist_checker import rph_pkg::*; #(
	parameter int NUM_BINS    = 256,
	parameter int COUNT_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	rph_pix_if   pix,
	rph_res_if   res,
	rph_cfg_if   cfg,
	output int   outstanding,
	output int   fail_count
);

	// shadow of the region registers
	logic                  roi_on;
	logic [CoordWidth-1:0] roi_left;
	logic [CoordWidth-1:0] roi_top;
	logic [CoordWidth-1:0] roi_right;
	logic [CoordWidth-1:0] roi_bottom;

	// shadow bins: a tally is only meaningful while its live mark is set
	logic [COUNT_WIDTH-1:0] bin_tally [NUM_BINS];
	logic                   bin_live  [NUM_BINS];

	// counts that pending reads should return, oldest first
	logic [ResWidth-1:0] read_counts [$];

	logic                counted;
	logic [ResWidth-1:0] want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_on     = 1'b0;
			roi_left   = '0;
			roi_top    = '0;
			roi_right  = RoiRightReset;
			roi_bottom = RoiBottomReset;
			for (int b = 0; b < NUM_BINS; b++)
				bin_live[b] = 1'b0;
			read_counts.delete();
			outstanding <= 0;
			fail_count = 0;
		end else begin
			// result side: compare with the oldest pending read
			if (res.valid && res.ready) begin
				if (read_counts.size() == 0) begin
					$error("bin_count: expected none, actual %0d", res.bin_count);
					fail_count++;
				end else begin
					want = read_counts.pop_front();
					if (res.bin_count !== want) begin
						$error("bin_count: expected %0d, actual %0d", want, res.bin_count);
						fail_count++;
					end
				end
			end

			// register writes; unused indexes change nothing
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_USE_ROI:    roi_on     = cfg.data[0];
					REG_ROI_LEFT:   roi_left   = cfg.data;
					REG_ROI_TOP:    roi_top    = cfg.data;
					REG_ROI_RIGHT:  roi_right  = cfg.data;
					REG_ROI_BOTTOM: roi_bottom = cfg.data;
					default: ;
				endcase
			end

			// input items
			if (pix.valid && pix.ready) begin
				case (pix.command)
					CMD_CLEAR: begin
						for (int b = 0; b < NUM_BINS; b++)
							bin_live[b] = 1'b0;
					end
					CMD_ADD: begin
						// inclusive bounds; an inverted rectangle counts nothing
						counted = !roi_on ||
							(pix.pixel_x >= roi_left && pix.pixel_x <= roi_right &&
							 pix.pixel_y >= roi_top && pix.pixel_y <= roi_bottom);
						if (counted && int'(pix.pixel_value) < NUM_BINS) begin
							if (!bin_live[pix.pixel_value]) begin
								bin_tally[pix.pixel_value] = COUNT_WIDTH'(1);
								bin_live[pix.pixel_value]  = 1'b1;
							end else if (bin_tally[pix.pixel_value] != '1) begin
								bin_tally[pix.pixel_value] =
									bin_tally[pix.pixel_value] + COUNT_WIDTH'(1);
							end
						end
					end
					CMD_READ: begin
						want = '0;
						if (int'(pix.bin_select) < NUM_BINS && bin_live[pix.bin_select])
							want = ResWidth'(bin_tally[pix.bin_select]);
						read_counts = {read_counts, want};
					end
					default: ;
				endcase
			end

			outstanding <= read_counts.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import rph_pkg::*;

	// command code the unit must ignore
	localparam logic [CmdWidth-1:0] CmdUnused = 2'd3;
	localparam logic [CoordWidth-1:0] CoordMax = '1;
	localparam logic [PixWidth-1:0] PixMax = '1;
	localparam int SettleCycles = 6;
	localparam int ItemsPerPhase = 118;
	localparam int NumPhases = 12;

	logic clk = 1'b0;
	logic arst_n;

	// idling percentages of sender and receiver
	int idle_pct = 0;
	int stall_pct = 0;

	int outstanding;
	int fails;

	// current region, used to aim coordinates at its edges
	logic [CoordWidth-1:0] cur_left, cur_top, cur_right, cur_bottom;
	logic [PixWidth-1:0] last_value;

	rph_pix_if pix ();
	rph_res_if res ();
	rph_cfg_if cfg ();

	roi_pixel_histogram_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	hist_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix         (pix),
		.res         (res),
		.cfg         (cfg),
		.outstanding (outstanding),
		.fail_count  (fails)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side back-pressure
	always @(posedge clk) begin
		res.ready <= ($urandom_range(99) >= stall_pct);
	end

	// one input item; valid is left high so back-to-back items need no gap
	task automatic send_item(input logic [CmdWidth-1:0] cmd, input logic [CoordWidth-1:0] x,
		input logic [CoordWidth-1:0] y, input logic [PixWidth-1:0] value,
		input logic [PixWidth-1:0] sel);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			pix.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		pix.valid       <= 1'b1;
		pix.command     <= cmd;
		pix.pixel_x     <= x;
		pix.pixel_y     <= y;
		pix.pixel_value <= value;
		pix.bin_select  <= sel;
		do @(posedge clk); while (!pix.ready);
	endtask

	// stop sending and wait for every pending read, then let the pipeline settle
	task automatic drain();
		pix.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CfgIdxWidth-1:0] idx,
		input logic [CfgDataWidth-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// write all five region registers; only bit 0 of the enable matters
	task automatic load_region(input logic on, input logic [CoordWidth-1:0] l,
		input logic [CoordWidth-1:0] t, input logic [CoordWidth-1:0] r,
		input logic [CoordWidth-1:0] b);
		put_reg(REG_USE_ROI,
			(CfgDataWidth'($urandom_range(0, 2047)) << 1) | CfgDataWidth'(on));
		put_reg(REG_ROI_LEFT, l);
		put_reg(REG_ROI_TOP, t);
		put_reg(REG_ROI_RIGHT, r);
		put_reg(REG_ROI_BOTTOM, b);
		cfg.valid <= 1'b0;
		cur_left   = l;
		cur_top    = t;
		cur_right  = r;
		cur_bottom = b;
	endtask

	// coordinate on or just beside an edge, or anywhere
	function automatic logic [CoordWidth-1:0] pick_coord(input logic [CoordWidth-1:0] lo,
		input logic [CoordWidth-1:0] hi);
		case ($urandom_range(3))
			0: return lo - CoordWidth'($urandom_range(1));
			1: return hi + CoordWidth'($urandom_range(1));
			default: return CoordWidth'($urandom);
		endcase
	endfunction

	task automatic random_region();
		logic [CoordWidth-1:0] a, b, c, d;
		a = CoordWidth'($urandom);
		b = CoordWidth'($urandom);
		c = CoordWidth'($urandom);
		d = CoordWidth'($urandom);
		case ($urandom_range(5))
			0: load_region(1'($urandom_range(1)), '0, '0, CoordMax, CoordMax);
			1: load_region(1'b1, a, c, a, c);
			// inverted rectangle when a and b differ: nothing is counted then
			2: load_region(1'b1, (a > b) ? a : b, c, (a > b) ? b : a, d);
			default: load_region($urandom_range(3) != 0, (a < b) ? a : b, (c < d) ? c : d,
				(a < b) ? b : a, (c < d) ? d : c);
		endcase
	endtask

	task automatic random_item();
		int r;
		logic [PixWidth-1:0] value, sel;
		r = $urandom_range(99);
		// adds favour a few hot bins and repeats of the last bin
		case ($urandom_range(3))
			0: value = last_value;
			1: value = PixWidth'($urandom_range(7));
			default: value = PixWidth'($urandom);
		endcase
		case ($urandom_range(4))
			0, 1: sel = last_value;
			2: sel = PixWidth'($urandom_range(7));
			default: sel = PixWidth'($urandom);
		endcase
		if (r < 4) begin
			send_item(CMD_CLEAR, CoordWidth'($urandom), CoordWidth'($urandom),
				PixWidth'($urandom), PixWidth'($urandom));
		end else if (r < 8) begin
			send_item(CmdUnused, CoordWidth'($urandom), CoordWidth'($urandom),
				PixWidth'($urandom), PixWidth'($urandom));
		end else if (r < 38) begin
			send_item(CMD_READ, CoordWidth'($urandom), CoordWidth'($urandom),
				PixWidth'($urandom), sel);
		end else begin
			send_item(CMD_ADD, pick_coord(cur_left, cur_right),
				pick_coord(cur_top, cur_bottom), value, PixWidth'($urandom));
			last_value = value;
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n          <= 1'b0;
		pix.valid       = 1'b0;
		pix.command     = CMD_CLEAR;
		pix.pixel_x     = '0;
		pix.pixel_y     = '0;
		pix.pixel_value = '0;
		pix.bin_select  = '0;
		res.ready       = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = REG_USE_ROI;
		cfg.data        = '0;
		cur_left        = '0;
		cur_top         = '0;
		cur_right       = CoordMax;
		cur_bottom      = CoordMax;
		last_value      = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset region counts everything; empty bins, field extremes, same-bin runs
		send_item(CMD_READ, '0, '0, '0, '0);
		send_item(CMD_READ, '0, '0, '0, PixMax);
		send_item(CMD_ADD, '0, '0, '0, '0);
		send_item(CMD_ADD, CoordMax, CoordMax, PixMax, PixMax);
		send_item(CMD_ADD, CoordMax, '0, PixMax, '0);
		send_item(CMD_ADD, '0, CoordMax, PixMax, '0);
		send_item(CMD_READ, '0, '0, '0, PixMax);
		send_item(CMD_READ, CoordMax, CoordMax, PixMax, '0);
		send_item(CmdUnused, CoordMax, CoordMax, PixMax, PixMax);
		send_item(CMD_READ, '0, '0, '0, '0);
		// flash clear, then bins restart from one
		send_item(CMD_CLEAR, '0, '0, '0, '0);
		send_item(CMD_READ, '0, '0, '0, PixMax);
		send_item(CMD_ADD, 12'd7, 12'd9, PixMax, '0);
		send_item(CMD_READ, '0, '0, '0, PixMax);
		send_item(CMD_READ, '0, '0, '0, '0);
		drain();

		// unused register indexes must leave the region alone
		for (int i = int'(REG_ROI_BOTTOM) + 1; i < (1 << CfgIdxWidth); i++)
			put_reg(CfgIdxWidth'(i), CfgDataWidth'($urandom));
		load_region(1'b1, 12'd100, 12'd200, 12'd300, 12'd400);

		// inclusive edges and one step outside each
		send_item(CMD_ADD, 12'd99, 12'd300, 8'd1, '0);
		send_item(CMD_ADD, 12'd100, 12'd200, 8'd1, '0);
		send_item(CMD_ADD, 12'd300, 12'd400, 8'd1, '0);
		send_item(CMD_ADD, 12'd301, 12'd300, 8'd1, '0);
		send_item(CMD_ADD, 12'd200, 12'd199, 8'd1, '0);
		send_item(CMD_ADD, 12'd200, 12'd401, 8'd1, '0);
		send_item(CMD_READ, '0, '0, '0, 8'd1);
		drain();

		// inverted region counts nothing
		load_region(1'b1, 12'd500, '0, 12'd499, CoordMax);
		send_item(CMD_ADD, 12'd500, 12'd100, 8'd2, '0);
		send_item(CMD_ADD, 12'd499, 12'd100, 8'd2, '0);
		send_item(CMD_READ, '0, '0, '0, 8'd2);
		drain();

		// random phases, each with its own region and idling mix
		for (int p = 0; p < NumPhases; p++) begin
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 64; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 64; end
				default: begin idle_pct = 13; stall_pct = 13; end
			endcase
			random_region();
			repeat (ItemsPerPhase) random_item();
			drain();
		end

		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
